>>> rtl/i2cm_pkg.sv
// Shared types and codes for the I2C master byte engine.
package i2cm_pkg;

    localparam logic [2:0] CMD_IDLE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Phase numbers inside the phase lists
    localparam logic [4:0] PH_FIRST      = 5'd0;
    localparam logic [4:0] PH_SECOND     = 5'd1;
    localparam logic [4:0] PH_THIRD      = 5'd2;
    localparam logic [4:0] PH_WR_ACK_SDA = 5'd24;
    localparam logic [4:0] PH_WR_ACK_SCL = 5'd25;
    localparam logic [4:0] PH_WR_ACK_END = 5'd26;
    localparam logic [4:0] PH_RD_BITS_END = 5'd16;
    localparam logic [4:0] PH_RD_ACK_SDA = 5'd17;
    localparam logic [4:0] PH_RD_ACK_SCL = 5'd18;
    localparam logic [4:0] PH_RD_ACK_LOW = 5'd19;
    localparam logic [4:0] PH_RD_ACK_REL = 5'd20;

    localparam logic [1:0] BIT_SET_SDA  = 2'd0;
    localparam logic [1:0] BIT_SCL_HIGH = 2'd1;
    localparam logic [1:0] BIT_SCL_LOW  = 2'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } i2cm_in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       acked;
    } i2cm_out_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] phase;
        logic [1:0] bit_step;   // phase mod 3 during the write bit phases
        logic [7:0] shift;
        logic       scl;
        logic       sda;
        logic       ack_seen;
        logic       ack_to_send;
        logic [7:0] rx_hold;
    } i2cm_state_t;

endpackage

>>> rtl/i2cm_phase_logic.sv
// Next-state and result logic for one bus phase of the I2C master.
module i2cm_phase_logic import i2cm_pkg::*; (
    input  i2cm_state_t cur_state,
    input  i2cm_in_t    in_word,
    output i2cm_state_t next_state,
    output i2cm_out_t   out_word
);

    i2cm_state_t st;
    logic        last;

    always_comb begin
        st   = cur_state;
        last = 1'b0;

        if (st.cmd == CMD_IDLE &&
            (in_word.func inside {CMD_START, CMD_STOP, CMD_WRITE, CMD_READ})) begin
            st.cmd      = in_word.func;
            st.phase    = PH_FIRST;
            st.bit_step = BIT_SET_SDA;
            if (in_word.func == CMD_WRITE) begin
                st.shift = in_word.tx_byte;
            end
            if (in_word.func == CMD_READ) begin
                st.shift       = 8'd0;
                st.ack_to_send = in_word.send_ack;
            end
        end

        case (st.cmd)
            CMD_START: begin
                case (st.phase)
                    PH_FIRST:  st.scl = 1'b1;
                    PH_SECOND: st.sda = 1'b0;
                    PH_THIRD: begin
                        st.scl = 1'b0;
                        last   = 1'b1;
                    end
                    default: last = 1'b1;
                endcase
            end
            CMD_STOP: begin
                case (st.phase)
                    PH_FIRST:  st.sda = 1'b0;
                    PH_SECOND: st.scl = 1'b1;
                    PH_THIRD: begin
                        st.sda = 1'b1;
                        last   = 1'b1;
                    end
                    default: last = 1'b1;
                endcase
            end
            CMD_WRITE: begin
                if (st.phase < PH_WR_ACK_SDA) begin
                    // MSB goes out, shifted away once its clock pulse ends
                    case (st.bit_step)
                        BIT_SET_SDA:  st.sda = st.shift[7];
                        BIT_SCL_HIGH: st.scl = 1'b1;
                        default: begin
                            st.scl   = 1'b0;
                            st.shift = {st.shift[6:0], 1'b0};
                        end
                    endcase
                end else begin
                    case (st.phase)
                        PH_WR_ACK_SDA: st.sda = 1'b1;
                        PH_WR_ACK_SCL: st.scl = 1'b1;
                        PH_WR_ACK_END: begin
                            st.scl      = 1'b0;
                            st.ack_seen = ~in_word.sda_in;
                            last        = 1'b1;
                        end
                        default: last = 1'b1;
                    endcase
                end
            end
            CMD_READ: begin
                if (st.phase == PH_FIRST) begin
                    st.sda = 1'b1;
                end else if (st.phase <= PH_RD_BITS_END) begin
                    if (st.phase[0]) begin
                        st.scl = 1'b1;
                    end else begin
                        st.scl   = 1'b0;
                        st.shift = {st.shift[6:0], in_word.sda_in};
                    end
                end else if (st.ack_to_send) begin
                    case (st.phase)
                        PH_RD_ACK_SDA: st.sda = 1'b0;
                        PH_RD_ACK_SCL: st.scl = 1'b1;
                        PH_RD_ACK_LOW: st.scl = 1'b0;
                        PH_RD_ACK_REL: begin
                            st.sda = 1'b1;
                            last   = 1'b1;
                        end
                        default: last = 1'b1;
                    endcase
                end else begin
                    case (st.phase)
                        PH_RD_ACK_SDA: st.sda = 1'b1;
                        PH_RD_ACK_SCL: st.scl = 1'b1;
                        PH_RD_ACK_LOW: begin
                            st.scl = 1'b0;
                            last   = 1'b1;
                        end
                        default: last = 1'b1;
                    endcase
                end
                if (last) begin
                    st.rx_hold = st.shift;
                end
            end
            CMD_IDLE: last = 1'b0;
            default:  last = 1'b1;
        endcase

        out_word.busy_res = 1'b0;
        out_word.done_res = 1'b0;
        if (st.cmd != CMD_IDLE) begin
            if (last) begin
                out_word.done_res = 1'b1;
                st.cmd      = CMD_IDLE;
                st.phase    = PH_FIRST;
                st.bit_step = BIT_SET_SDA;
            end else begin
                out_word.busy_res = 1'b1;
                st.phase    = st.phase + 5'd1;
                st.bit_step = (st.bit_step == BIT_SCL_LOW) ? BIT_SET_SDA
                                                           : st.bit_step + 2'd1;
            end
        end

        out_word.scl_out = st.scl;
        out_word.sda_out = st.sda;
        out_word.rx_byte = st.rx_hold;
        out_word.acked   = st.ack_seen;
        next_state       = st;
    end

endmodule

>>> rtl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: state and result registers.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  s_      | in        | s_valid / s_ready  | func, tx_byte, send_ack, sda_in
//  m_      | out       | m_valid / m_ready  | scl_out, sda_out, busy_res,
//          |           |                    | done_res, rx_byte, acked
//
// One word in, one word out; each input word is one bus phase, and a word
// can enter every cycle unless m_ready stalls the output. The result appears
// in the output register on the cycle after acceptance. s_ready is high while
// the output register is empty or being drained, so a stall on m_ready holds
// both sides. Synchronous active-low reset sets the SCL/SDA state idle high.
module i2c_master_byte_engine import i2cm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  i2cm_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output i2cm_out_t m_data
);

    i2cm_state_t state_reg, state_next;
    i2cm_out_t   out_reg, out_next;
    logic        m_valid_reg;
    logic        accept;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    i2cm_phase_logic u_phase (
        .cur_state  (state_reg),
        .in_word    (s_data),
        .next_state (state_next),
        .out_word   (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.cmd         <= CMD_IDLE;
            state_reg.phase       <= PH_FIRST;
            state_reg.bit_step    <= BIT_SET_SDA;
            state_reg.shift       <= 8'd0;
            state_reg.scl         <= 1'b1;
            state_reg.sda         <= 1'b1;
            state_reg.ack_seen    <= 1'b0;
            state_reg.ack_to_send <= 1'b0;
            state_reg.rx_hold     <= 8'd0;
            m_valid_reg           <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the I2C master byte engine: phase predictor and random bus traffic.
`timescale 1ns / 1ps

module testbench import i2cm_pkg::*; ();

    localparam int RANDOM_WORDS = 1150;

    typedef enum {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_drive_t;

    // Tracks the pin sequencer phase by phase and holds the pin words still due.
    class pin_sequence_tracker_t;
        logic [2:0] cmd;
        logic [4:0] phase;
        logic [7:0] shift;
        logic       scl;
        logic       sda;
        logic       ack_seen;
        logic       ack_to_send;
        logic [7:0] rx_hold;
        i2cm_out_t  levels_due[$];
        int         errors;
        int         words_in;
        int         words_out;
        int         started[5];

        function new();
            cmd         = CMD_IDLE;
            phase       = PH_FIRST;
            shift       = '0;
            scl         = 1'b1;
            sda         = 1'b1;
            ack_seen    = 1'b0;
            ack_to_send = 1'b0;
            rx_hold     = '0;
            errors      = 0;
            words_in    = 0;
            words_out   = 0;
            foreach (started[i]) started[i] = 0;
        endfunction

        function logic busy();
            return cmd != CMD_IDLE;
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        // Runs the current phase; returns 1 on the last phase of the command.
        function logic advance_phase(logic sda_in);
            logic [2:0] bit_idx;
            logic [4:0] step;
            case (cmd)
                CMD_START: begin
                    case (phase)
                        PH_FIRST:  scl = 1'b1;
                        PH_SECOND: sda = 1'b0;
                        PH_THIRD:  scl = 1'b0;
                        default: ;
                    endcase
                    return phase >= PH_THIRD;
                end
                CMD_STOP: begin
                    case (phase)
                        PH_FIRST:  sda = 1'b0;
                        PH_SECOND: scl = 1'b1;
                        PH_THIRD:  sda = 1'b1;
                        default: ;
                    endcase
                    return phase >= PH_THIRD;
                end
                CMD_WRITE: begin
                    if (phase < PH_WR_ACK_SDA) begin
                        bit_idx = 3'(phase / 5'd3);
                        step    = phase % 5'd3;
                        if (step == 5'(BIT_SET_SDA)) sda = shift[3'd7 - bit_idx];
                        else if (step == 5'(BIT_SCL_HIGH)) scl = 1'b1;
                        else scl = 1'b0;
                        return 1'b0;
                    end
                    case (phase)
                        PH_WR_ACK_SDA: sda = 1'b1;
                        PH_WR_ACK_SCL: scl = 1'b1;
                        PH_WR_ACK_END: begin
                            scl      = 1'b0;
                            ack_seen = !sda_in;
                        end
                        default: ;
                    endcase
                    return phase >= PH_WR_ACK_END;
                end
                CMD_READ: begin
                    if (phase == PH_FIRST) begin
                        sda = 1'b1;
                        return 1'b0;
                    end
                    if (phase <= PH_RD_BITS_END) begin
                        // odd phases raise SCL, even ones lower it and take the bit
                        if (phase[0]) begin
                            scl = 1'b1;
                        end else begin
                            scl   = 1'b0;
                            shift = {shift[6:0], sda_in};
                        end
                        return 1'b0;
                    end
                    if (ack_to_send) begin
                        case (phase)
                            PH_RD_ACK_SDA: sda = 1'b0;
                            PH_RD_ACK_SCL: scl = 1'b1;
                            PH_RD_ACK_LOW: scl = 1'b0;
                            PH_RD_ACK_REL: sda = 1'b1;
                            default: ;
                        endcase
                        if (phase < PH_RD_ACK_REL) return 1'b0;
                    end else begin
                        case (phase)
                            PH_RD_ACK_SDA: sda = 1'b1;
                            PH_RD_ACK_SCL: scl = 1'b1;
                            PH_RD_ACK_LOW: scl = 1'b0;
                            default: ;
                        endcase
                        if (phase < PH_RD_ACK_LOW) return 1'b0;
                    end
                    rx_hold = shift;
                    return 1'b1;
                end
                default: return 1'b1;
            endcase
        endfunction

        function void take_word(i2cm_in_t w);
            i2cm_out_t r;
            words_in++;
            if (cmd == CMD_IDLE && w.func >= CMD_START && w.func <= CMD_READ) begin
                cmd   = w.func;
                phase = PH_FIRST;
                started[w.func]++;
                if (w.func == CMD_WRITE) shift = w.tx_byte;
                if (w.func == CMD_READ) begin
                    shift       = '0;
                    ack_to_send = w.send_ack;
                end
            end
            r.busy_res = 1'b0;
            r.done_res = 1'b0;
            if (cmd != CMD_IDLE) begin
                if (advance_phase(w.sda_in)) begin
                    r.done_res = 1'b1;
                    cmd        = CMD_IDLE;
                    phase      = PH_FIRST;
                end else begin
                    r.busy_res = 1'b1;
                    phase      = phase + 5'd1;
                end
            end
            r.scl_out = scl;
            r.sda_out = sda;
            r.rx_byte = rx_hold;
            r.acked   = ack_seen;
            levels_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_word(i2cm_out_t got);
            i2cm_out_t want;
            words_out++;
            if (levels_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word: expected none, actual %h",
                         $time, got);
                return;
            end
            want = levels_due.pop_front();
            compare_field("scl_out",  8'(want.scl_out),  8'(got.scl_out));
            compare_field("sda_out",  8'(want.sda_out),  8'(got.sda_out));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("rx_byte",  want.rx_byte,      got.rx_byte);
            compare_field("acked",    8'(want.acked),    8'(got.acked));
        endfunction

        function void finish_check();
            if (levels_due.size() != 0) begin
                errors += levels_due.size();
                $display("%0t: %0d result words never arrived", $time, levels_due.size());
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    i2cm_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    i2cm_out_t m_data;

    pin_sequence_tracker_t sb;
    bit no_gaps   = 1'b0;
    int ready_hold = 0;

    always #5 aclk = ~aclk;

    i2c_master_byte_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Receiver back-pressure: short stalls, a few long ones, some stall-free runs.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    m_ready    <= 1'b1;
                    ready_hold = $urandom_range(20, 60);
                end
                2: begin
                    m_ready    <= 1'b0;
                    ready_hold = $urandom_range(8, 30);
                end
                3, 4, 5, 6, 7: begin
                    m_ready    <= 1'b0;
                    ready_hold = $urandom_range(0, 2);
                end
                default: begin
                    m_ready    <= 1'b1;
                    ready_hold = $urandom_range(0, 4);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_data);
    end

    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic pick_sda(sda_drive_t mode);
        case (mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_word(i2cm_in_t w);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.take_word(w);
    endtask

    // Issues one func word, then ticks with junk func until the command ends.
    task automatic run_command(logic [2:0] f, logic [7:0] tx, logic ack, sda_drive_t mode);
        i2cm_in_t w;
        w.func     = f;
        w.tx_byte  = tx;
        w.send_ack = ack;
        w.sda_in   = pick_sda(mode);
        send_word(w);
        while (sb.busy()) begin
            w.func     = 3'($urandom_range(0, 7));
            w.tx_byte  = 8'($urandom);
            w.send_ack = 1'($urandom_range(0, 1));
            w.sda_in   = pick_sda(mode);
            send_word(w);
        end
    endtask

    function automatic logic [2:0] idle_func();
        logic [2:0] f;
        f = 3'($urandom_range(0, 3));
        return (f == CMD_IDLE) ? CMD_IDLE : f + 3'd4;
    endfunction

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        int  waited;
        int  base;
        bit  drained;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // idle ticks, unknown funcs, then every command at its extremes
        run_command(CMD_IDLE, 8'h00, 1'b0, SDA_LOW);
        run_command(CMD_IDLE, 8'hFF, 1'b1, SDA_HIGH);
        run_command(3'd5, 8'hFF, 1'b1, SDA_RANDOM);
        run_command(3'd6, 8'h00, 1'b0, SDA_RANDOM);
        run_command(3'd7, 8'hA5, 1'b1, SDA_RANDOM);
        run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
        run_command(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW);
        run_command(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH);
        run_command(CMD_READ, 8'h00, 1'b1, SDA_HIGH);
        run_command(CMD_READ, 8'hFF, 1'b0, SDA_LOW);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
        wait_for_drain();

        base    = sb.words_in;
        drained = 1'b0;
        while (sb.words_in < base + RANDOM_WORDS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85) begin
                // well-formed transaction: START, a few bytes, STOP
                run_command(CMD_START, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM);
                repeat ($urandom_range(1, 3))
                    run_command($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 8'($urandom),
                                1'($urandom_range(0, 1)), SDA_RANDOM);
                run_command(CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM);
            end else begin
                // noise and commands in no particular order
                repeat ($urandom_range(1, 4))
                    run_command(3'($urandom_range(0, 7)), 8'($urandom),
                                1'($urandom_range(0, 1)), SDA_RANDOM);
            end
            repeat ($urandom_range(0, 2))
                run_command(idle_func(), 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM);
            if (!drained && sb.words_in > base + RANDOM_WORDS / 2) begin
                wait_for_drain();
                drained = 1'b1;
            end
        end
        s_valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        sb.finish_check();

        $display("Run covered %0d phase words and %0d checked results.",
                 sb.words_in, sb.words_out);
        $display("Commands taken: start %0d, stop %0d, write %0d, read %0d; %0d mismatches.",
                 sb.started[CMD_START], sb.started[CMD_STOP], sb.started[CMD_WRITE],
                 sb.started[CMD_READ], sb.errors);
        if (sb.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/i2cm_pkg.sv
rtl/i2cm_phase_logic.sv
rtl/i2c_master_byte_engine.sv
verif/testbench.sv
